FILE: rtl/socc_pkg.sv
package socc_pkg;

  // Segment layout.
  localparam int unsigned HEADER_BYTES       = 32;
  localparam int unsigned PAYLOAD_LEN_OFFSET = 28;
  localparam int unsigned MAX_SEGMENT_BYTES  = 1478;

  localparam logic [15:0] WORD_MASK   = 16'hFFFF;
  localparam logic [15:0] COUNT_SAT   = 16'hFFFF;
  localparam logic [15:0] LEN_POS_HI  = 16'(PAYLOAD_LEN_OFFSET);
  localparam logic [15:0] LEN_POS_LO  = 16'(PAYLOAD_LEN_OFFSET + 1);
  localparam logic [15:0] CSUM_POS    = 16'(HEADER_BYTES - 2);
  localparam logic [16:0] HDR_LEN     = 17'(HEADER_BYTES);
  localparam logic [15:0] MAX_SEG_LEN = 16'(MAX_SEGMENT_BYTES);

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_MAX = 2'd2,
    ST_ODD = 2'd3
  } status_t;

  // Segment totals as they stand once the current byte is taken in.
  typedef struct packed {
    logic [15:0] sum;
    logic [15:0] size;
    logic [15:0] decl_len;
  } seg_total_t;

endpackage

FILE: rtl/socc_in_if.sv
interface socc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

FILE: rtl/socc_out_if.sv
interface socc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum_value;
  logic [1:0]  status;

  modport source (output valid, output checksum_value, output status, input ready);
  modport sink (input valid, input checksum_value, input status, output ready);
endinterface

FILE: rtl/socc_accum.sv
module socc_accum (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [7:0]             data_byte,
  input  logic                   is_last,
  output socc_pkg::seg_total_t   tot
);
  import socc_pkg::*;

  logic [15:0] sum_r, sum_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] decl_r, decl_nxt;
  logic        pos_live;
  logic [15:0] word;
  logic [16:0] sum_wide;
  logic [15:0] sum_fold;

  assign pos_live = (count_r != COUNT_SAT);
  assign word     = {hold_r, data_byte};
  assign sum_wide = {1'b0, sum_r} + {1'b0, word};
  // End-around carry.
  assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    hold_nxt  = hold_r;
    decl_nxt  = decl_r;
    if (pos_live) begin
      if (count_r == LEN_POS_HI) begin
        decl_nxt[15:8] = data_byte;
      end
      if (count_r == LEN_POS_LO) begin
        decl_nxt[7:0] = data_byte;
      end
      if (!count_r[0]) begin
        hold_nxt = data_byte;
      end else if ({count_r[15:1], 1'b0} != CSUM_POS) begin
        sum_nxt = sum_fold;
      end
      count_nxt = count_r + 16'd1;
    end
  end

  assign tot.sum      = sum_nxt;
  assign tot.size     = count_nxt;
  assign tot.decl_len = decl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
      hold_r  <= '0;
      decl_r  <= '0;
    end else if (go) begin
      if (is_last) begin
        sum_r   <= '0;
        count_r <= '0;
        hold_r  <= '0;
        decl_r  <= '0;
      end else begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
        hold_r  <= hold_nxt;
        decl_r  <= decl_nxt;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    go && is_last |=> count_r == 16'd0 && sum_r == 16'd0 && decl_r == 16'd0)
    else $error("segment state not cleared after last byte");

  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    go && !is_last && count_r == COUNT_SAT |=> count_r == COUNT_SAT)
    else $error("byte counter wrapped");

endmodule

FILE: rtl/socc_verdict.sv
module socc_verdict (
  input  socc_pkg::seg_total_t tot,
  output logic [15:0]          csum,
  output socc_pkg::status_t    status
);
  import socc_pkg::*;

  logic [16:0] need_len;

  assign need_len = HDR_LEN + {1'b0, tot.decl_len};

  always_comb begin
    if (need_len > {1'b0, tot.size}) begin
      status = ST_LEN;
    end else if (tot.size > MAX_SEG_LEN) begin
      status = ST_MAX;
    end else if (tot.size[0]) begin
      status = ST_ODD;
    end else begin
      status = ST_OK;
    end
  end

  assign csum = (status == ST_OK) ? (tot.sum ^ WORD_MASK) : 16'd0;

endmodule

FILE: rtl/segment_ones_complement_checksum_core.sv
// A last byte waits for a free result slot; its result is held there until taken.
// Throughput: one byte per cycle unless a last byte waits on a busy result slot;
// the input register feeds the byte accumulator and the final status logic in a
// single pass into the result register.
// Reset: synchronous, active low; clears the running sum, byte count, length
// field and both valid flags. A stalled result stalls only a following last byte.
module segment_ones_complement_checksum_core (
  input  logic         clk,
  input  logic         rst_n,
  socc_in_if.sink      in_ch,
  socc_out_if.source   out_ch
);
  import socc_pkg::*;

  // Input register stage.
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_go;

  // Result register stage.
  logic        out_v_r;
  logic [15:0] out_csum_r;
  status_t     out_status_r;

  seg_total_t  tot;
  logic [15:0] csum;
  status_t     status;
  logic        out_free;

  // The result slot frees up when empty or when its transaction completes.
  assign out_free = !out_v_r || out_ch.ready;

  // A non-last byte never needs the result slot; a last byte waits for it.
  assign s1_go = s1_v_r && (!s1_last_r || out_free);

  // Take a new transaction whenever the input register empties this cycle.
  assign in_ch.ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  // Payload: hold while stalled, load on every free slot.
  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.is_last;
    end
  end

  socc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (s1_go),
    .data_byte (s1_byte_r),
    .is_last   (s1_last_r),
    .tot       (tot)
  );

  socc_verdict u_verdict (
    .tot    (tot),
    .csum   (csum),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_csum_r   <= csum;
      out_status_r <= status;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.checksum_value = out_csum_r;
  assign out_ch.status         = out_status_r;

  a_bad_status_zero_csum: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_OK) || (out_ch.checksum_value == 16'd0))
    else $error("checksum nonzero with error status");

  a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> out_v_r)
    else $error("last byte produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r && s1_last_r && out_v_r && !out_ch.ready)
    else $error("input stalled without a blocked result");

endmodule
